// File: design/dstq_pkg.sv
// Shared constants and types for the deadline sorted timer queue.
package dstq_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_BITS_DEF  = 48;
  localparam int TMO_BITS       = 31;

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_DEFINE    = 3'd1;
  localparam logic [2:0] CMD_START     = 3'd2;
  localparam logic [2:0] CMD_STOP      = 3'd3;
  localparam logic [2:0] CMD_CHANGE    = 3'd4;
  localparam logic [2:0] CMD_CHANGE_OS = 3'd5;

  localparam logic [2:0] OP_HOLD    = 3'd0;
  localparam logic [2:0] OP_CLR     = 3'd1;
  localparam logic [2:0] OP_FLAG    = 3'd2;
  localparam logic [2:0] OP_COMPACT = 3'd3;
  localparam logic [2:0] OP_INSERT  = 3'd4;
  localparam logic [2:0] OP_MARK    = 3'd5;
  localparam logic [2:0] OP_POP     = 3'd6;

  typedef struct packed {
    logic [2:0] op;
  } ctl_t;

endpackage

// File: design/dstq_cell.sv
// One queue entry cell: holds a timer id and deadline, shifts with its neighbors.
module dstq_cell #(
  parameter int IDW = 4,
  parameter int TW  = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  dstq_pkg::ctl_t   ctl,
  input  logic [IDW-1:0]   key_id,
  input  logic [TW-1:0]    key_dl,
  input  logic [TW-1:0]    now,
  input  logic             left_valid,
  input  logic [IDW-1:0]   left_id,
  input  logic [TW-1:0]    left_dl,
  input  logic             left_mark,
  input  logic             left_flag,
  input  logic             left_gt,
  input  logic             right_valid,
  input  logic [IDW-1:0]   right_id,
  input  logic [TW-1:0]    right_dl,
  input  logic             right_mark,
  output logic             valid,
  output logic [IDW-1:0]   id,
  output logic [TW-1:0]    dl,
  output logic             mark,
  output logic             flag,
  output logic             gt
);

  assign gt = !valid || (!mark && (dl > key_dl));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      mark  <= 1'b0;
      flag  <= 1'b0;
    end else begin
      case (ctl.op)
        dstq_pkg::OP_CLR: begin
          flag <= 1'b0;
        end
        dstq_pkg::OP_FLAG: begin
          flag <= left_flag || (valid && (id == key_id));
        end
        dstq_pkg::OP_COMPACT: begin
          if (flag) begin
            valid <= right_valid;
            id    <= right_id;
            dl    <= right_dl;
            mark  <= right_mark;
          end
          flag <= 1'b0;
        end
        dstq_pkg::OP_INSERT: begin
          if (gt) begin
            if (left_gt) begin
              valid <= left_valid;
              id    <= left_id;
              dl    <= left_dl;
              mark  <= left_mark;
            end else begin
              valid <= 1'b1;
              id    <= key_id;
              dl    <= key_dl;
              mark  <= 1'b0;
            end
          end
        end
        dstq_pkg::OP_MARK: begin
          mark <= valid && (dl <= now);
        end
        dstq_pkg::OP_POP: begin
          valid <= right_valid;
          id    <= right_id;
          dl    <= right_dl;
          mark  <= right_mark;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/deadline_sorted_timer_queue_unit.sv
// Top level of the deadline sorted timer queue: sequencer, slot store and cell chain.
//
// Input channel (in_valid / in_stall) takes one command beat: cmd, timer_id,
// delay_ms, repeat_mode. Output channel (out_valid / out_stall) gives one
// beat per expired timer: fired, fired_id, last; last marks the final beat
// of a tick. Ticks with nothing due and all other commands give no beat.
// The queue is a chain of NUM_TIMERS cells kept sorted by deadline.
// Start, stop, define and change first take the slot out of the chain: a
// match flag ripples one cell per cycle through the whole chain, then a
// compaction step closes the gap, then for start and both change commands
// an insert step puts the slot back. A tick marks the due cells, then for
// each expired timer pops and reports it, then re-arms a periodic one from
// the slot store, whose read is registered. in_stall stays high until the command is done.
// A stalled output beat holds the sequencer in its pop step, so nothing is
// lost. Reset empties the queue, clears time and makes every slot a
// one-shot timer with zero timeout; the block is ready the cycle after.
module deadline_sorted_timer_queue_unit #(
  parameter int NUM_TIMERS = dstq_pkg::NUM_TIMERS_DEF,
  parameter int TIME_BITS  = dstq_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [3:0]  timer_id,
  input  logic [30:0] delay_ms,
  input  logic        repeat_mode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        fired,
  output logic [3:0]  fired_id,
  output logic        last
);

  localparam int IDW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TW  = TIME_BITS;
  localparam int TB  = dstq_pkg::TMO_BITS;
  localparam logic [NUM_TIMERS-1:0] ONE_N = 1;
  localparam logic [IDW-1:0] CNT_END = IDW'(NUM_TIMERS - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FLAG    = 3'd1;
  localparam logic [2:0] S_COMPACT = 3'd2;
  localparam logic [2:0] S_INSERT  = 3'd3;
  localparam logic [2:0] S_MARK    = 3'd4;
  localparam logic [2:0] S_POP     = 3'd5;
  localparam logic [2:0] S_REINS   = 3'd6;

  logic [2:0]     state;
  logic [2:0]     state_next;
  logic [IDW-1:0] cnt;
  logic [TW-1:0]  now;
  logic [2:0]     op_cmd;
  logic [IDW-1:0] op_id;
  logic [TB-1:0]  op_tmo;
  logic [IDW-1:0] pop_id;

  logic [TB-1:0]  slot_tmo [NUM_TIMERS];
  logic           slot_per [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] tmo_ok;
  logic [NUM_TIMERS-1:0] per_ok;
  logic [TB-1:0]  rd_tmo;
  logic           rd_per;
  logic           rd_tmo_ok;
  logic           rd_per_ok;
  logic [IDW-1:0] rd_addr;
  logic [TB-1:0]  tmo_eff;
  logic           per_eff;

  dstq_pkg::ctl_t ctl;
  logic [IDW-1:0] key_id;
  logic [TW-1:0]  key_dl;

  logic [NUM_TIMERS-1:0] c_valid;
  logic [NUM_TIMERS-1:0] c_mark;
  logic [NUM_TIMERS-1:0] c_flag;
  logic [NUM_TIMERS-1:0] c_gt;
  logic [IDW-1:0] c_id [NUM_TIMERS];
  logic [TW-1:0]  c_dl [NUM_TIMERS];

  logic in_take;
  logic in_range;
  logic out_free;
  logic head_due;
  logic ins_ok;
  logic [IDW-1:0] in_id;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign in_range = (32'(timer_id) < NUM_TIMERS);
  assign in_id    = IDW'(timer_id);
  assign out_free = !out_valid || !out_stall;
  assign head_due = c_valid[0] && c_mark[0];
  assign ins_ok   = !c_valid[NUM_TIMERS-1];
  assign tmo_eff  = rd_tmo_ok ? rd_tmo : '0;
  assign per_eff  = rd_per_ok ? rd_per : 1'b0;
  assign rd_addr  = (state == S_IDLE) ? in_id : c_id[0];

  always_ff @(posedge clk) begin
    if (in_take && in_range && (cmd == dstq_pkg::CMD_DEFINE
        || cmd == dstq_pkg::CMD_CHANGE || cmd == dstq_pkg::CMD_CHANGE_OS)) begin
      slot_tmo[in_id] <= delay_ms;
    end
    if (in_take && in_range && (cmd == dstq_pkg::CMD_DEFINE
        || cmd == dstq_pkg::CMD_CHANGE_OS)) begin
      slot_per[in_id] <= (cmd == dstq_pkg::CMD_DEFINE) ? repeat_mode : 1'b0;
    end
    if (state == S_IDLE || state == S_POP) begin
      rd_tmo <= slot_tmo[rd_addr];
      rd_per <= slot_per[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tmo_ok    <= '0;
      per_ok    <= '0;
      rd_tmo_ok <= 1'b0;
      rd_per_ok <= 1'b0;
    end else begin
      if (in_take && in_range && (cmd == dstq_pkg::CMD_DEFINE
          || cmd == dstq_pkg::CMD_CHANGE || cmd == dstq_pkg::CMD_CHANGE_OS)) begin
        tmo_ok[in_id] <= 1'b1;
      end
      if (in_take && in_range && (cmd == dstq_pkg::CMD_DEFINE
          || cmd == dstq_pkg::CMD_CHANGE_OS)) begin
        per_ok[in_id] <= 1'b1;
      end
      if (state == S_IDLE || state == S_POP) begin
        rd_tmo_ok <= tmo_ok[rd_addr];
        rd_per_ok <= per_ok[rd_addr];
      end
    end
  end

  always_comb begin
    state_next = state;
    ctl.op     = dstq_pkg::OP_HOLD;
    key_id     = op_id;
    key_dl     = TW'(now + TW'(((op_cmd == dstq_pkg::CMD_START) ? tmo_eff : op_tmo)));
    case (state)
      S_IDLE: begin
        ctl.op = dstq_pkg::OP_CLR;
        if (in_take) begin
          if (cmd == dstq_pkg::CMD_TICK) begin
            state_next = S_MARK;
          end else if (in_range && (cmd == dstq_pkg::CMD_DEFINE || cmd == dstq_pkg::CMD_START
              || cmd == dstq_pkg::CMD_STOP || cmd == dstq_pkg::CMD_CHANGE
              || cmd == dstq_pkg::CMD_CHANGE_OS)) begin
            state_next = S_FLAG;
          end
        end
      end
      S_FLAG: begin
        ctl.op = dstq_pkg::OP_FLAG;
        if (cnt == CNT_END) begin
          state_next = S_COMPACT;
        end
      end
      S_COMPACT: begin
        ctl.op = dstq_pkg::OP_COMPACT;
        if (op_cmd == dstq_pkg::CMD_DEFINE || op_cmd == dstq_pkg::CMD_STOP) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        ctl.op     = ins_ok ? dstq_pkg::OP_INSERT : dstq_pkg::OP_HOLD;
        state_next = S_IDLE;
      end
      S_MARK: begin
        ctl.op     = dstq_pkg::OP_MARK;
        state_next = S_POP;
      end
      S_POP: begin
        if (!head_due) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          ctl.op     = dstq_pkg::OP_POP;
          state_next = S_REINS;
        end
      end
      S_REINS: begin
        key_id     = pop_id;
        key_dl     = TW'(now + TW'(tmo_eff));
        ctl.op     = (per_eff && ins_ok) ? dstq_pkg::OP_INSERT : dstq_pkg::OP_HOLD;
        state_next = S_POP;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      now       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FLAG) begin
        cnt <= cnt + IDW'(1);
      end else begin
        cnt <= '0;
      end
      if (in_take && cmd == dstq_pkg::CMD_TICK) begin
        now <= TW'(now + TW'(1));
      end
      if (state == S_POP && head_due && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_cmd <= cmd;
      op_id  <= in_id;
      op_tmo <= delay_ms;
    end
    if (state == S_POP && head_due && out_free) begin
      pop_id   <= c_id[0];
      fired    <= 1'b1;
      fired_id <= 4'(c_id[0]);
      last     <= !(c_valid[1] && c_mark[1]);
    end
  end

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    logic           l_valid;
    logic [IDW-1:0] l_id;
    logic [TW-1:0]  l_dl;
    logic           l_mark;
    logic           l_flag;
    logic           l_gt;
    logic           r_valid;
    logic [IDW-1:0] r_id;
    logic [TW-1:0]  r_dl;
    logic           r_mark;
    if (i == 0) begin : g_first
      assign l_valid = 1'b0;
      assign l_id    = '0;
      assign l_dl    = '0;
      assign l_mark  = 1'b0;
      assign l_flag  = 1'b0;
      assign l_gt    = 1'b0;
    end else begin : g_mid
      assign l_valid = c_valid[i-1];
      assign l_id    = c_id[i-1];
      assign l_dl    = c_dl[i-1];
      assign l_mark  = c_mark[i-1];
      assign l_flag  = c_flag[i-1];
      assign l_gt    = c_gt[i-1];
    end
    if (i == NUM_TIMERS - 1) begin : g_end
      assign r_valid = 1'b0;
      assign r_id    = '0;
      assign r_dl    = '0;
      assign r_mark  = 1'b0;
    end else begin : g_inner
      assign r_valid = c_valid[i+1];
      assign r_id    = c_id[i+1];
      assign r_dl    = c_dl[i+1];
      assign r_mark  = c_mark[i+1];
    end
    dstq_cell #(.IDW(IDW), .TW(TW)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .key_id      (key_id),
      .key_dl      (key_dl),
      .now         (now),
      .left_valid  (l_valid),
      .left_id     (l_id),
      .left_dl     (l_dl),
      .left_mark   (l_mark),
      .left_flag   (l_flag),
      .left_gt     (l_gt),
      .right_valid (r_valid),
      .right_id    (r_id),
      .right_dl    (r_dl),
      .right_mark  (r_mark),
      .valid       (c_valid[i]),
      .id          (c_id[i]),
      .dl          (c_dl[i]),
      .mark        (c_mark[i]),
      .flag        (c_flag[i]),
      .gt          (c_gt[i])
    );
  end

  a_valid_packed: assert property (@(posedge clk) disable iff (rst)
    (c_valid & (c_valid + ONE_N)) == '0)
    else $error("queue cells not packed at the head");

  a_mark_prefix: assert property (@(posedge clk) disable iff (rst)
    ((c_mark & (c_mark + ONE_N)) == '0) && ((c_mark & ~c_valid) == '0))
    else $error("due marks not a prefix of valid cells");

  a_beat_from_pop: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP && head_due && out_free) |=> (out_valid && state == S_REINS))
    else $error("pop did not produce an output beat");

endmodule

// File: verif/dstq_checker.sv
// Checker for the deadline sorted timer queue: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module dstq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [3:0]  timer_id,
  input  logic [30:0] delay_ms,
  input  logic        repeat_mode,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        fired,
  input  logic [3:0]  fired_id,
  input  logic        last,
  output int          fail_count,
  output int          pending,
  output int          fire_count
);

  localparam int NT = dstq_pkg::NUM_TIMERS_DEF;

  typedef struct packed {
    logic [3:0] id;
    logic       lst;
  } fire_t;

  logic [47:0] now_ms;
  logic [30:0] tmo_of [NT];
  logic        per_of [NT];
  logic [47:0] due_at [NT];
  logic [3:0]  order [$];
  fire_t       fires_due [$];

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void unlink(input logic [3:0] id);
    logic [3:0] kept [$];
    foreach (order[i]) if (order[i] != id) kept.push_back(order[i]);
    order = kept;
  endfunction

  function automatic void link(input logic [3:0] id);
    int p;
    p = 0;
    if (order.size() >= NT) return;
    while (p < order.size() && due_at[order[p]] <= due_at[id]) p++;
    order.insert(p, id);
  endfunction

  function automatic void rearm(input logic [3:0] id);
    unlink(id);
    due_at[id] = now_ms + 48'(tmo_of[id]);
    link(id);
  endfunction

  function automatic void apply_beat(input logic [2:0] c, input logic [3:0] id,
                                     input logic [30:0] t, input logic r);
    logic [3:0] hit [$];
    logic [3:0] kept [$];
    if (c == dstq_pkg::CMD_TICK) begin
      now_ms = now_ms + 48'd1;
      foreach (order[i])
        if (due_at[order[i]] <= now_ms) hit.push_back(order[i]);
        else kept.push_back(order[i]);
      order = kept;
      foreach (hit[i]) begin
        if (per_of[hit[i]]) begin
          due_at[hit[i]] = now_ms + 48'(tmo_of[hit[i]]);
          link(hit[i]);
        end
        fires_due.push_back('{id: hit[i], lst: (i == hit.size() - 1)});
      end
      return;
    end
    case (c)
      dstq_pkg::CMD_DEFINE: begin
        unlink(id);
        tmo_of[id] = t;
        per_of[id] = r;
        due_at[id] = '0;
      end
      dstq_pkg::CMD_START: rearm(id);
      dstq_pkg::CMD_STOP: unlink(id);
      dstq_pkg::CMD_CHANGE: begin
        tmo_of[id] = t;
        rearm(id);
      end
      dstq_pkg::CMD_CHANGE_OS: begin
        tmo_of[id] = t;
        per_of[id] = 1'b0;
        rearm(id);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    fire_t want;
    if (rst) begin
      now_ms = '0;
      for (int i = 0; i < NT; i++) begin
        tmo_of[i] = '0;
        per_of[i] = 1'b0;
        due_at[i] = '0;
      end
      order.delete();
      fires_due.delete();
      fail_count = 0;
      fire_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        fire_count++;
        if (fires_due.size() == 0) begin
          report($sformatf("unexpected beat id %0d", fired_id));
        end else begin
          want = fires_due.pop_front();
          if (fired !== 1'b1) report("fired not set");
          if (fired_id !== want.id)
            report($sformatf("fired_id %0d, want %0d", fired_id, want.id));
          if (last !== want.lst)
            report($sformatf("last %0b, want %0b", last, want.lst));
        end
      end
      if (in_valid && !in_stall) apply_beat(cmd, timer_id, delay_ms, repeat_mode);
    end
    pending = fires_due.size();
  end

endmodule

// File: verif/tb_deadline_sorted_timer_queue_unit.sv
// Testbench top for the deadline sorted timer queue: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_deadline_sorted_timer_queue_unit;

  localparam longint MAX_CYCLES = 2000000;
  localparam logic [2:0] CMD_RSVD_A = 3'd6;
  localparam logic [2:0] CMD_RSVD_B = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = dstq_pkg::CMD_TICK;
  logic [3:0]  timer_id = '0;
  logic [30:0] delay_ms = '0;
  logic        repeat_mode = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        fired;
  logic [3:0]  fired_id;
  logic        last;
  int          fail_count, pending, fire_count, beats_sent;
  longint      cycles = 0;
  logic        quiet_out = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  deadline_sorted_timer_queue_unit i_dut (.*);

  dstq_checker i_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (quiet_out || rst) out_stall <= 1'b0;
    else out_stall <= (gap_len() != 0);
  end

  task automatic send(input logic [2:0] c, input logic [3:0] id,
                      input logic [30:0] t, input logic r, input bit idle);
    int g;
    g = idle ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    timer_id <= id;
    delay_ms <= t;
    repeat_mode <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  function automatic logic [30:0] rand_tmo();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 31'($urandom_range(0, 6));
    if (r < 18) return 31'($urandom_range(7, 40));
    return 31'($urandom);
  endfunction

  initial begin
    logic [2:0] c;
    int r;
    beats_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero timeout, max timeout, ties, stop of idle slot, odd commands
    send(dstq_pkg::CMD_TICK, 4'd0, '0, 1'b0, 0);
    send(dstq_pkg::CMD_DEFINE, 4'd0, 31'd0, 1'b1, 0);
    send(dstq_pkg::CMD_DEFINE, 4'd15, 31'h7FFF_FFFF, 1'b1, 0);
    send(dstq_pkg::CMD_DEFINE, 4'd5, 31'd2, 1'b0, 0);
    send(dstq_pkg::CMD_DEFINE, 4'd6, 31'd2, 1'b0, 0);
    send(dstq_pkg::CMD_START, 4'd0, '0, 1'b0, 0);
    send(dstq_pkg::CMD_START, 4'd15, '0, 1'b0, 0);
    send(dstq_pkg::CMD_START, 4'd6, '0, 1'b0, 0);
    send(dstq_pkg::CMD_START, 4'd5, '0, 1'b0, 0);
    send(dstq_pkg::CMD_STOP, 4'd9, '0, 1'b0, 0);
    send(dstq_pkg::CMD_TICK, 4'd0, '0, 1'b0, 0);
    send(dstq_pkg::CMD_TICK, 4'd0, '0, 1'b0, 0);
    send(dstq_pkg::CMD_CHANGE, 4'd5, 31'd1, 1'b1, 0);
    send(CMD_RSVD_A, 4'd5, 31'h5555_5555, 1'b1, 0);
    send(CMD_RSVD_B, 4'd10, 31'h2AAA_AAAA, 1'b0, 0);
    send(dstq_pkg::CMD_CHANGE_OS, 4'd0, 31'd1, 1'b0, 0);
    send(dstq_pkg::CMD_TICK, 4'd0, '0, 1'b0, 0);
    send(dstq_pkg::CMD_DEFINE, 4'd0, 31'd3, 1'b0, 0);
    send(dstq_pkg::CMD_STOP, 4'd15, '0, 1'b0, 0);
    send(dstq_pkg::CMD_TICK, 4'd0, '0, 1'b0, 0);
    send(dstq_pkg::CMD_TICK, 4'd0, '0, 1'b0, 0);

    for (int n = 0; n < 430; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) c = dstq_pkg::CMD_TICK;
      else if (r < 52) c = dstq_pkg::CMD_DEFINE;
      else if (r < 70) c = dstq_pkg::CMD_START;
      else if (r < 80) c = dstq_pkg::CMD_STOP;
      else if (r < 88) c = dstq_pkg::CMD_CHANGE;
      else if (r < 96) c = dstq_pkg::CMD_CHANGE_OS;
      else c = ($urandom_range(0, 1) != 0) ? CMD_RSVD_B : CMD_RSVD_A;
      send(c, 4'($urandom), rand_tmo(), 1'($urandom), 1);
    end
    in_valid <= 1'b0;
    quiet_out <= 1'b1;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("sent %0d command beats, checked %0d expiry beats", beats_sent, fire_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: deadline_sorted_timer_queue_unit.f
design/dstq_pkg.sv
design/dstq_cell.sv
design/deadline_sorted_timer_queue_unit.sv
verif/dstq_checker.sv
verif/tb_deadline_sorted_timer_queue_unit.sv
